### hdl/ppe_pkg.sv
// shared types and constants for the point-in-polygon engine
// request kinds, ring rule constant and the controller/datapath command and status groups
// no dependencies
package ppe_pkg;

  // request kind codes carried on s_tuser[1:0]
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // a ring takes part in queries once it holds this many vertices
  localparam int MIN_RING_LEN = 3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic issue;
    logic load_result;
  } ppe_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic out_busy;
  } ppe_sts_t;

endpackage

### hdl/ppe_ctrl.sv
// controller state machine of the point-in-polygon engine
// sequences clear, append and query requests and drives datapath commands
// depends on ppe_pkg
module ppe_ctrl
  import ppe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  kind_t    kind,
  output logic     s_tready,
  output ppe_cmd_t cmd,
  input  ppe_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CLEAR:  cmd.clear = 1'b1;
            KIND_APPEND: cmd.append = 1'b1;
            KIND_QUERY: begin
              cmd.query_start = 1'b1;
              state_next      = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/ppe_datapath.sv
// datapath of the point-in-polygon engine
// vertex memory, ring counters, edge walk, crossing compare pipeline and output register
// depends on ppe_pkg
module ppe_datapath
  import ppe_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ppe_cmd_t                     cmd,
  output ppe_sts_t                     sts,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_begin,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         out_inside,
  output logic                         out_trunc
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CB = COORD_BITS;
  localparam int VW = 2 * CB + 1;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;

  // vertex memory: {start, y, x}
  logic [VW-1:0] mem [MAX_VERTICES];

  // ring bookkeeping
  logic [CW-1:0] wc, cc, ors;
  logic          ovf;
  logic [CW-1:0] ring_len, base, ors_new, wc_inc, new_len;
  logic          has_room;

  // walk state
  logic signed [CB-1:0] px, py;
  logic [CW-1:0] addr, n;
  logic          rd_valid, rd_first, rd_last;
  logic [VW-1:0] rd_data;
  logic signed [CB-1:0] first_x, first_y, prev_x, prev_y;
  logic          close_pend;

  // edge and compare pipeline
  logic                 e_valid;
  logic signed [CB-1:0] e_cx, e_cy, e_nx, e_ny;
  logic                 s1_valid;
  logic signed [DW-1:0] s1_d, s1_a, s1_cx, s1_e;
  logic                 s2_valid, s2_dpos;
  logic signed [PW-1:0] s2_p1, s2_p2;
  logic                 parity;
  logic                 straddle, left;

  logic signed [CB-1:0] v_x, v_y;
  logic                 v_start;

  assign v_x     = rd_data[CB-1:0];
  assign v_y     = rd_data[2*CB-1:CB];
  assign v_start = rd_data[VW-1] || rd_first;

  // append placement
  always_comb begin
    ring_len = wc - ors;
    base     = (in_begin && (ring_len < CW'(MIN_RING_LEN))) ? ors : wc;
    ors_new  = in_begin ? base : ors;
    has_room = base < CW'(MAX_VERTICES);
    wc_inc   = base + 1'b1;
    new_len  = wc_inc - ors_new;
  end

  // ring counters and drop flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wc  <= '0;
      cc  <= '0;
      ors <= '0;
      ovf <= 1'b0;
    end else if (cmd.append) begin
      ors <= ors_new;
      if (has_room) begin
        wc <= wc_inc;
        if (new_len >= CW'(MIN_RING_LEN)) cc <= wc_inc;
      end else begin
        wc  <= base;
        ovf <= 1'b1;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.append && has_room) begin
      mem[base[AW-1:0]] <= {(base == ors_new), in_y, in_x};
    end
    rd_data <= mem[addr[AW-1:0]];
  end

  assign sts.issue_done = (addr == n);

  // read issue
  always_ff @(posedge clk) begin
    if (rst) begin
      addr     <= '0;
      n        <= '0;
      rd_valid <= 1'b0;
      rd_first <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      if (cmd.query_start) begin
        addr <= '0;
        n    <= cc;
        px   <= in_x;
        py   <= in_y;
      end else if (cmd.issue && !sts.issue_done) begin
        addr     <= addr + 1'b1;
        rd_valid <= 1'b1;
        rd_first <= (addr == '0);
        rd_last  <= ((addr + 1'b1) == n);
      end
    end
  end

  // edge forming: one edge a cycle, closing each ring back to its first vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid    <= 1'b0;
      close_pend <= 1'b0;
    end else begin
      e_valid <= 1'b0;
      if (rd_valid) begin
        prev_x <= v_x;
        prev_y <= v_y;
        if (v_start) begin
          first_x <= v_x;
          first_y <= v_y;
          if (!rd_first) begin
            e_valid <= 1'b1;
            e_cx    <= prev_x;
            e_cy    <= prev_y;
            e_nx    <= first_x;
            e_ny    <= first_y;
          end
        end else begin
          e_valid <= 1'b1;
          e_cx    <= prev_x;
          e_cy    <= prev_y;
          e_nx    <= v_x;
          e_ny    <= v_y;
        end
        close_pend <= rd_last;
      end else if (close_pend) begin
        close_pend <= 1'b0;
        e_valid    <= 1'b1;
        e_cx       <= prev_x;
        e_cy       <= prev_y;
        e_nx       <= first_x;
        e_ny       <= first_y;
      end
    end
  end

  assign straddle = (e_ny > py) != (e_cy > py);

  // differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= e_valid && straddle;
    end
    s1_d  <= {e_cy[CB-1], e_cy} - {e_ny[CB-1], e_ny};
    s1_a  <= {px[CB-1], px} - {e_nx[CB-1], e_nx};
    s1_cx <= {e_cx[CB-1], e_cx} - {e_nx[CB-1], e_nx};
    s1_e  <= {py[CB-1], py} - {e_ny[CB-1], e_ny};
  end

  // cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_p1   <= s1_a * s1_d;
    s2_p2   <= s1_cx * s1_e;
    s2_dpos <= s1_d > 0;
  end

  assign left = s2_dpos ? (s2_p1 < s2_p2) : (s2_p2 < s2_p1);

  // crossing parity
  always_ff @(posedge clk) begin
    if (rst || cmd.query_start) begin
      parity <= 1'b0;
    end else if (s2_valid && left) begin
      parity <= !parity;
    end
  end

  assign sts.pipe_busy = rd_valid || close_pend || e_valid || s1_valid || s2_valid;
  assign sts.out_busy  = m_tvalid && !m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.load_result) begin
      out_inside <= parity;
      out_trunc  <= ovf;
    end
  end

  // checks
  a_commit_le_written: assert property (@(posedge clk) disable iff (rst) cc <= wc)
    else $error("committed count exceeds written count");
  a_written_le_max: assert property (@(posedge clk) disable iff (rst)
    wc <= CW'(MAX_VERTICES))
    else $error("written count exceeds capacity");
  a_ring_start_le_written: assert property (@(posedge clk) disable iff (rst) ors <= wc)
    else $error("open ring start beyond written count");
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a pending result");

endmodule

### hdl/point_in_polygon_engine.sv
// Point-in-polygon engine, even-odd crossing rule, signed Q12.4 coordinates.
// Requests arrive on the s_ channel: s_tuser[1:0] is the kind (clear, append
// vertex, query point), s_tuser[2] marks the first vertex of a new ring, and
// s_tdata carries x in the low half and y above it. A query returns one word
// on the m_ channel: m_tdata[0] inside flag, m_tdata[1] sticky drop flag.
// Clear and append give no result. A query walks all committed vertices
// through the single read port of the vertex memory, one vertex a cycle, then
// drains a short compare pipeline. s_tready is low while a query runs. The
// result sits in an output register, so the next request is taken while it
// waits; a second query holds its result until the first one has been taken.
// Reset empties all rings and clears the drop flag; the memory itself needs no
// clearing.
// depends on ppe_pkg, ppe_ctrl, ppe_datapath
module point_in_polygon_engine
  import ppe_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // coord_x, coord_y, zero fill
  input  logic [2:0]                            s_tuser,  // kind[1:0], begins_ring
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata   // inside_res, truncated, zero fill
);

  ppe_cmd_t cmd;
  ppe_sts_t sts;
  kind_t    kind;
  logic     inside_res, truncated;

  assign kind = kind_t'(s_tuser[1:0]);

  ppe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (kind),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ppe_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_x       (s_tdata[COORD_BITS-1:0]),
    .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_begin   (s_tuser[2]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_inside (inside_res),
    .out_trunc  (truncated)
  );

  // result word
  assign m_tdata = {6'b0, truncated, inside_res};

endmodule

### sim/tb_point_in_polygon_engine.sv
// testbench for point_in_polygon_engine: clear, append and query requests on the s_ stream,
// answers checked on the m_ stream against an even-odd crossing predictor kept in step here
// depends on ppe_pkg and point_in_polygon_engine
`timescale 1ns / 1ps

module tb_point_in_polygon_engine;
  import ppe_pkg::*;

  localparam int STORE_DEPTH    = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = STORE_DEPTH + 16;
  localparam int RANDOM_ITEMS   = 700;

  typedef struct packed {
    logic in_poly;
    logic truncated;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // coord_x, coord_y
  logic [2:0]  s_tuser;   // kind[1:0], begins_ring
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // inside_res, truncated, zero fill

  // shadow of the vertex store and ring bookkeeping
  logic signed [15:0] pg_x [STORE_DEPTH];
  logic signed [15:0] pg_y [STORE_DEPTH];
  logic               pg_head [STORE_DEPTH];
  int                 pg_written;
  int                 pg_committed;
  int                 pg_ring_base;
  logic               pg_dropped;

  answer_t pending_answers [$];
  int      mismatch_cnt;
  int      items_sent;
  int      idle_cycles;
  bit      tx_gap_en;
  bit      rx_stall_en;
  bit      hold_req;

  // vertices of the current random episode, used to aim queries at edge y values
  logic signed [15:0] ep_x [$];
  logic signed [15:0] ep_y [$];

  point_in_polygon_engine #(
    .MAX_VERTICES(STORE_DEPTH),
    .COORD_BITS  (16)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // even-odd parity over all committed edges, exact cross-multiplied compare
  function automatic logic crossing_parity(input longint px, input longint py);
    logic   parity;
    logic   left;
    int     ring_first;
    int     nxt;
    longint cx, cy, nx, ny, d, a, dx, e;
    parity     = 1'b0;
    ring_first = 0;
    for (int i = 0; i < pg_committed; i++) begin
      if (pg_head[i]) ring_first = i;
      nxt = (i + 1 < pg_committed && !pg_head[i + 1]) ? i + 1 : ring_first;
      cx = pg_x[i];
      cy = pg_y[i];
      nx = pg_x[nxt];
      ny = pg_y[nxt];
      if ((ny > py) != (cy > py)) begin
        d  = cy - ny;
        a  = px - nx;
        dx = cx - nx;
        e  = py - ny;
        if (d > 0) left = (a * d) < (dx * e);
        else left = (dx * e) < (a * d);
        if (left) parity = ~parity;
      end
    end
    return parity;
  endfunction

  // update the shadow state for one accepted request, queue the answer of a query
  task automatic track_request(input kind_t kind, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic b);
    answer_t ans;
    case (kind)
      KIND_CLEAR: begin
        pg_written   = 0;
        pg_committed = 0;
        pg_ring_base = 0;
        pg_dropped   = 1'b0;
      end
      KIND_APPEND: begin
        if (b) begin
          // a ring that never reached the minimum is thrown away
          if (pg_written - pg_ring_base < MIN_RING_LEN) pg_written = pg_ring_base;
          pg_ring_base = pg_written;
        end
        if (pg_written < STORE_DEPTH) begin
          pg_x[pg_written]    = x;
          pg_y[pg_written]    = y;
          pg_head[pg_written] = (pg_written == pg_ring_base);
          pg_written++;
          if (pg_written - pg_ring_base >= MIN_RING_LEN) pg_committed = pg_written;
        end else begin
          pg_dropped = 1'b1;
        end
      end
      KIND_QUERY: begin
        ans.in_poly   = crossing_parity(x, y);
        ans.truncated = pg_dropped;
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // offer one request, wait for the handshake, then maybe leave a gap
  task automatic send_req(input kind_t kind, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic b);
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= {b, kind};
    do @(posedge clk); while (!s_tready);
    track_request(kind, x, y, b);
    if (kind != KIND_NONE) items_sent++;
    if (tx_gap_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic append_vtx(input int x, input int y, input logic b);
    send_req(KIND_APPEND, 16'(x), 16'(y), b);
  endtask

  task automatic query_pt(input int x, input int y);
    send_req(KIND_QUERY, 16'(x), 16'(y), 1'b0);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each answer with the oldest pending one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected answer: inside=%0d truncated=%0d", m_tdata[0], m_tdata[1]);
        mismatch_cnt++;
      end else begin
        if (m_tdata[0] !== pending_answers[0].in_poly ||
            m_tdata[1] !== pending_answers[0].truncated) begin
          if (mismatch_cnt < 10)
            $display("mismatch: expected inside=%0d truncated=%0d, got inside=%0d truncated=%0d",
                     pending_answers[0].in_poly, pending_answers[0].truncated,
                     m_tdata[0], m_tdata[1]);
          mismatch_cnt++;
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_point_in_polygon_engine: FAIL");
        $finish;
      end
    end
  end

  // query on an empty store, ignored kind in between
  task automatic test_empty_store();
    query_pt(0, 0);
    send_req(KIND_NONE, 16'h7fff, 16'h8000, 1'b1);
    query_pt(-32768, 32767);
  endtask

  // square whose first vertex has no begin mark, queries inside, outside, on vertex y
  task automatic test_square();
    send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    append_vtx(-160, -160, 1'b0);
    append_vtx(160, -160, 1'b0);
    append_vtx(160, 160, 1'b0);
    append_vtx(-160, 160, 1'b0);
    query_pt(0, 0);
    query_pt(400, 0);
    query_pt(0, -160);
    query_pt(-160, 160);
  endtask

  // short ring dropped by the next ring begin, hole ring inside the outer one
  task automatic test_rings();
    append_vtx(5000, 5000, 1'b1);
    append_vtx(5100, 5000, 1'b0);
    append_vtx(-40, -40, 1'b1);
    append_vtx(40, -40, 1'b0);
    append_vtx(0, 40, 1'b0);
    query_pt(0, 0);
    query_pt(5050, 5000);
  endtask

  // coordinates at both ends of the range
  task automatic test_extremes();
    send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    append_vtx(-32768, -32768, 1'b1);
    append_vtx(32767, -32768, 1'b0);
    append_vtx(0, 32767, 1'b0);
    query_pt(0, 0);
    query_pt(32767, 32767);
    query_pt(-32768, -32768);
  endtask

  // receiver holds off while queries keep coming, so the input stalls
  task automatic test_output_hold();
    send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    append_vtx(0, 0, 1'b1);
    append_vtx(800, 0, 1'b0);
    append_vtx(0, 800, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) query_pt($urandom_range(0, 900), $urandom_range(0, 900));
    while (hold_req) @(posedge clk);
  endtask

  // fill the store past capacity, end with a ring begin on a full store, then clear
  task automatic test_store_full();
    int n;
    n = 0;
    send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    while (n < STORE_DEPTH + 8) begin
      append_vtx($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                 (n % 40) == 0);
      n++;
    end
    append_vtx(10, 10, 1'b1);
    for (int i = 0; i < 3; i++)
      query_pt($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
    send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    query_pt(0, 0);
  endtask

  function automatic int near_pt(input int center, input bit wide);
    if (wide) return int'($signed(16'($urandom)));
    return center + int'($urandom_range(0, 511)) - 256;
  endfunction

  // one episode: usually a clear, a few rings with random content, then queries
  task automatic run_episode();
    bit wide;
    bit big;
    int rings, len, ccx, ccy, pick, qx, qy;
    logic b;
    wide = ($urandom_range(0, 5) == 0);
    big  = ($urandom_range(0, 39) == 0);
    tx_gap_en   = ($urandom_range(0, 3) != 0);
    rx_stall_en = ($urandom_range(0, 3) != 0);
    ccx = int'($urandom_range(0, 8000)) - 4000;
    ccy = int'($urandom_range(0, 8000)) - 4000;
    ep_x.delete();
    ep_y.delete();
    if ($urandom_range(0, 9) != 0) send_req(KIND_CLEAR, 16'sd0, 16'sd0, 1'b0);
    rings = big ? 8 : $urandom_range(1, 4);
    for (int r = 0; r < rings; r++) begin
      if (big) len = $urandom_range(20, 50);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 10);
      for (int v = 0; v < len; v++) begin
        // mostly well formed: begin mark on the first vertex only
        b = (v == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
        ep_x.push_back(16'(near_pt(ccx, wide)));
        ep_y.push_back(16'(near_pt(ccy, wide)));
        send_req(KIND_APPEND, ep_x[$], ep_y[$], b);
        if ($urandom_range(0, 29) == 0)
          send_req(KIND_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    repeat ($urandom_range(2, 6)) begin
      pick = $urandom_range(0, ep_x.size() - 1);
      qx = near_pt(ccx, wide);
      qy = near_pt(ccy, wide);
      case ($urandom_range(0, 3))
        0: qy = ep_y[pick];
        1: qx = ep_x[pick];
        default: ;
      endcase
      query_pt(qx, qy);
    end
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) run_episode();
  endtask

  initial begin
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= '0;
    pg_written   = 0;
    pg_committed = 0;
    pg_ring_base = 0;
    pg_dropped   = 1'b0;
    mismatch_cnt = 0;
    items_sent   = 0;
    tx_gap_en    = 1'b0;
    rx_stall_en  = 1'b0;
    hold_req     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_square();
    test_rings();
    test_extremes();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
    test_output_hold();
    test_store_full();
    test_random();

    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_point_in_polygon_engine: PASS");
    end else begin
      $display("tb_point_in_polygon_engine: FAIL");
    end
    $finish;
  end

endmodule
